// ===== rtl/pce_pkg.sv =====
// shared types and constants for the pilot channel equalizer
// used by pce_soft_div and pilot_channel_equalizer_core, no dependencies
package pce_pkg;

    localparam int SAMPLE_W = 16;
    localparam int EST_W    = 17;
    localparam int ACC_W    = 34;
    localparam int DEN_W    = 32;
    localparam int SOFT_W   = 16;
    localparam int QUO_BITS = 15;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 64;

    localparam logic OP_PILOT = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // register select is paddr[3]: 0 low sign word, 1 high sign word
    localparam logic REG_SIGNS_LOW  = 1'b0;
    localparam logic REG_SIGNS_HIGH = 1'b1;

    typedef struct packed {
        logic signed [EST_W-1:0] re;
        logic signed [EST_W-1:0] im;
    } t_est;

endpackage

// ===== rtl/pce_soft_div.sv =====
// serial soft-symbol divider: trunc(num * 2^14 / den) saturated to 16 bits
// one shared subtract/compare unit, real part then imaginary part
// depends on pce_pkg; numerators and denominator must hold until done
module pce_soft_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [pce_pkg::ACC_W-1:0]      i_num_re,
    input  logic signed [pce_pkg::ACC_W-1:0]      i_num_im,
    input  logic        [pce_pkg::DEN_W-1:0]      i_den,
    output logic                                  o_done,
    output logic signed [pce_pkg::SOFT_W-1:0]     o_soft_re,
    output logic signed [pce_pkg::SOFT_W-1:0]     o_soft_im
);

    localparam logic [1:0] DV_IDLE  = 2'd0;
    localparam logic [1:0] DV_CHECK = 2'd1;
    localparam logic [1:0] DV_STEP  = 2'd2;

    localparam int RW = pce_pkg::DEN_W + 1;

    logic [1:0]                        r_state;
    logic                              r_part;
    logic                              r_neg;
    logic                              r_sat;
    logic [3:0]                        r_cnt;
    logic [RW-1:0]                     r_rem;
    logic [pce_pkg::QUO_BITS-1:0]      r_quo;
    logic                              r_done;
    logic signed [pce_pkg::SOFT_W-1:0] r_soft_re;
    logic signed [pce_pkg::SOFT_W-1:0] r_soft_im;

    logic [RW-1:0]                     sub_b;
    logic [RW:0]                       diff;
    logic                              ge;
    logic [RW-1:0]                     rem_kept;
    logic [pce_pkg::QUO_BITS-1:0]      quo_next;
    logic signed [pce_pkg::SOFT_W-1:0] soft_val;
    logic signed [pce_pkg::ACC_W-1:0]  num_sel;
    logic signed [pce_pkg::ACC_W-1:0]  num_abs;

    // the shared unit: compare against 2*den for the overflow check, den otherwise
    assign sub_b    = (r_state == DV_CHECK) ? {i_den, 1'b0} : {1'b0, i_den};
    assign diff     = {1'b0, r_rem} - {1'b0, sub_b};
    assign ge       = ~diff[RW];
    assign rem_kept = ge ? diff[RW-1:0] : r_rem;
    assign quo_next = {r_quo[pce_pkg::QUO_BITS-2:0], ge};

    always_comb begin
        if (r_sat) begin
            soft_val = r_neg ? pce_pkg::SOFT_W'(16'sh8000) : pce_pkg::SOFT_W'(16'sh7FFF);
        end else if (r_neg) begin
            soft_val = -$signed({1'b0, quo_next});
        end else begin
            soft_val = $signed({1'b0, quo_next});
        end
    end

    // numerator for the part about to start
    assign num_sel = (r_state == DV_IDLE) ? i_num_re : i_num_im;
    assign num_abs = num_sel[pce_pkg::ACC_W-1] ? -num_sel : num_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_part  <= 1'b0;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                DV_IDLE: begin
                    if (i_start) begin
                        r_state <= DV_CHECK;
                        r_part  <= 1'b0;
                    end
                end
                DV_CHECK: begin
                    r_cnt   <= '0;
                    r_state <= DV_STEP;
                end
                DV_STEP: begin
                    if (r_cnt == 4'(pce_pkg::QUO_BITS - 1)) begin
                        if (r_part) begin
                            r_state <= DV_IDLE;
                            r_done  <= 1'b1;
                        end else begin
                            r_part  <= 1'b1;
                            r_state <= DV_CHECK;
                        end
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                default: begin
                    r_state <= DV_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            DV_IDLE: begin
                r_rem <= num_abs[RW-1:0];
                r_neg <= num_sel[pce_pkg::ACC_W-1];
                r_quo <= '0;
            end
            DV_CHECK: begin
                // |num| >= 2*den means the quotient reaches 32768
                r_sat <= ge;
                r_quo <= '0;
            end
            DV_STEP: begin
                r_quo <= quo_next;
                r_rem <= {rem_kept[RW-2:0], 1'b0};
                if (r_cnt == 4'(pce_pkg::QUO_BITS - 1)) begin
                    if (r_part) begin
                        r_soft_im <= soft_val;
                    end else begin
                        r_soft_re <= soft_val;
                        r_rem     <= num_abs[RW-1:0];
                        r_neg     <= num_sel[pce_pkg::ACC_W-1];
                    end
                end
            end
            default: begin
                r_quo <= '0;
            end
        endcase
    end

    assign o_done    = r_done;
    assign o_soft_re = r_soft_re;
    assign o_soft_im = r_soft_im;

endmodule

// ===== rtl/pilot_channel_equalizer_core.sv =====
// pilot channel equalizer top level: estimate memory, shared multiplier,
// sequencer, apb sign registers; depends on pce_pkg and pce_soft_div
//
// usage:
//   input beats are taken when start is high and busy is low. a pilot beat
//   (opcode 0) writes the channel estimate of its subcarrier in that same
//   cycle and gives no result; busy stays low, so pilots go one per cycle.
//   a data beat (opcode 1) raises busy and, after the estimate read, the
//   products and the divisions, puts one result on the o_ result ports with
//   o_valid high for exactly one cycle. busy falls in that cycle, so a new beat
//   can be taken with it. the time is set by one 17x17 multiplier shared over
//   six products and one subtract/compare unit that runs two divisions (a
//   range check and 15 steps each), plus the estimate memory read and control.
//   when the channel magnitude is zero the division is skipped and the result
//   comes with divide_error set.
//   the receiver cannot stall: a result is gone after its strobe cycle.
//   the user must see that the sign registers are written through the apb port
//   only while idle; the block itself does not enforce this.
//   reset clears the sequencer and both sign registers; the estimate memory
//   is not cleared, so every subcarrier needs a pilot before its data.
module pilot_channel_equalizer_core #(
    parameter int SUBCARRIERS = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_opcode,
    input  logic        [5:0]                     i_subcarrier,
    input  logic signed [pce_pkg::SAMPLE_W-1:0]   i_sample_re,
    input  logic signed [pce_pkg::SAMPLE_W-1:0]   i_sample_im,
    output logic                                  o_valid,
    output logic        [5:0]                     o_out_subcarrier,
    output logic signed [31:0]                    o_equalized_re,
    output logic signed [31:0]                    o_equalized_im,
    output logic        [1:0]                     o_data_bits,
    output logic signed [pce_pkg::SOFT_W-1:0]     o_soft_re,
    output logic signed [pce_pkg::SOFT_W-1:0]     o_soft_im,
    output logic                                  o_divide_error,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic        [pce_pkg::APB_AW-1:0]     paddr,
    input  logic        [pce_pkg::APB_DW-1:0]     pwdata,
    output logic        [pce_pkg::APB_DW-1:0]     prdata,
    output logic                                  pready
);

    localparam int AW = (SUBCARRIERS > 1) ? $clog2(SUBCARRIERS) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_POST = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;

    localparam int EW = pce_pkg::EST_W;
    localparam int CW = pce_pkg::ACC_W;

    // ---------------- configuration ----------------
    logic [63:0] r_signs_low;
    logic [63:0] r_signs_high;
    logic        cfg_wr;

    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[3] == pce_pkg::REG_SIGNS_HIGH) ? r_signs_high : r_signs_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signs_low  <= '0;
            r_signs_high <= '0;
        end else if (cfg_wr) begin
            if (paddr[3] == pce_pkg::REG_SIGNS_LOW) begin
                r_signs_low <= pwdata;
            end else begin
                r_signs_high <= pwdata;
            end
        end
    end

    // ---------------- pilot estimate ----------------
    logic                 accept;
    logic                 in_range;
    logic [AW-1:0]        addr;
    logic [63:0]          sign_word;
    logic                 sgn_re;
    logic                 sgn_im;
    logic signed [EW-1:0] x_ext;
    logic signed [EW-1:0] y_ext;
    logic signed [EW:0]   est_sum_re;
    logic signed [EW:0]   est_sum_im;
    pce_pkg::t_est        pilot_est;

    assign accept    = start & ~busy;
    assign in_range  = 32'(i_subcarrier) < SUBCARRIERS;
    assign addr      = AW'(i_subcarrier);
    assign sign_word = i_subcarrier[5] ? r_signs_high : r_signs_low;
    assign sgn_re    = sign_word[{i_subcarrier[4:0], 1'b0}];
    assign sgn_im    = sign_word[{i_subcarrier[4:0], 1'b1}];
    assign x_ext     = EW'(i_sample_re);
    assign y_ext     = EW'(i_sample_im);

    // conj(r) * p with p = +-1 +- j, then floor half
    assign est_sum_re = (EW+1)'(sgn_re ? x_ext : -x_ext) + (EW+1)'(sgn_im ? y_ext : -y_ext);
    assign est_sum_im = (EW+1)'(sgn_im ? x_ext : -x_ext) + (EW+1)'(sgn_re ? -y_ext : y_ext);
    assign pilot_est.re = est_sum_re[EW:1];
    assign pilot_est.im = est_sum_im[EW:1];

    pce_pkg::t_est r_mem [SUBCARRIERS];
    pce_pkg::t_est r_rd_est;

    always_ff @(posedge i_clk) begin
        if (accept && in_range) begin
            if (i_opcode == pce_pkg::OP_PILOT) begin
                r_mem[addr] <= pilot_est;
            end else begin
                r_rd_est <= r_mem[addr];
            end
        end
    end

    // ---------------- sequencer ----------------
    logic [2:0]                       r_state;
    logic [2:0]                       n_state;
    logic [2:0]                       r_cnt;
    logic                             r_valid;
    logic                             r_inside;
    logic [5:0]                       r_k;
    logic signed [EW-1:0]             r_x;
    logic signed [EW-1:0]             r_y;
    logic signed [CW-1:0]             r_prod;
    logic signed [CW-1:0]             r_er;
    logic signed [CW-1:0]             r_ei;
    logic signed [CW-1:0]             r_mag;
    logic signed [EW-1:0]             est_c;
    logic signed [EW-1:0]             est_d;
    logic signed [EW-1:0]             mul_a;
    logic signed [EW-1:0]             mul_b;
    logic signed [CW-1:0]             mul_p;
    logic                             finish;
    logic                             mag_zero;
    logic                             div_start;
    logic                             div_done;
    logic signed [pce_pkg::SOFT_W-1:0] div_soft_re;
    logic signed [pce_pkg::SOFT_W-1:0] div_soft_im;

    assign est_c    = r_inside ? r_rd_est.re : '0;
    assign est_d    = r_inside ? r_rd_est.im : '0;
    assign mag_zero = (r_mag == '0);

    always_comb begin
        unique case (r_cnt)
            3'd0:    begin mul_a = r_x;   mul_b = est_c; end
            3'd1:    begin mul_a = r_y;   mul_b = est_d; end
            3'd2:    begin mul_a = r_x;   mul_b = est_d; end
            3'd3:    begin mul_a = r_y;   mul_b = est_c; end
            3'd4:    begin mul_a = est_c; mul_b = est_c; end
            default: begin mul_a = est_d; mul_b = est_d; end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign div_start = (r_state == ST_POST) && !mag_zero;
    assign finish = ((r_state == ST_POST) && mag_zero) || ((r_state == ST_DIV) && div_done);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept && i_opcode == pce_pkg::OP_DATA) n_state = ST_READ;
            ST_READ: n_state = ST_MUL;
            ST_MUL:  if (r_cnt == 3'd6) n_state = ST_POST;
            ST_POST: n_state = mag_zero ? ST_IDLE : ST_DIV;
            ST_DIV:  if (div_done) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= finish;
            if (r_state == ST_MUL) begin
                r_cnt <= r_cnt + 3'd1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_k      <= i_subcarrier;
            r_x      <= x_ext;
            r_y      <= y_ext;
            r_inside <= in_range;
        end
        if (r_state == ST_MUL) begin
            r_prod <= mul_p;
            // accumulate the product issued in the previous cycle
            unique case (r_cnt)
                3'd1:    r_er  <= r_prod;
                3'd2:    r_er  <= r_er - r_prod;
                3'd3:    r_ei  <= r_prod;
                3'd4:    r_ei  <= r_ei + r_prod;
                3'd5:    r_mag <= r_prod;
                3'd6:    r_mag <= r_mag + r_prod;
                default: begin
                end
            endcase
        end
    end

    pce_soft_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_num_re  (r_er),
        .i_num_im  (r_ei),
        .i_den     (r_mag[pce_pkg::DEN_W-1:0]),
        .o_done    (div_done),
        .o_soft_re (div_soft_re),
        .o_soft_im (div_soft_im)
    );

    // ---------------- result register ----------------
    function automatic logic signed [31:0] sat32(input logic signed [CW-1:0] v);
        logic signed [31:0] res;
        if (v[CW-1:31] == '0 || v[CW-1:31] == '1) begin
            res = v[31:0];
        end else begin
            res = v[CW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (finish) begin
            o_out_subcarrier <= r_k;
            o_equalized_re   <= sat32(r_er);
            o_equalized_im   <= sat32(r_ei);
            o_data_bits      <= {(!r_ei[CW-1] && r_ei != '0), (!r_er[CW-1] && r_er != '0)};
            o_divide_error   <= mag_zero;
            o_soft_re        <= mag_zero ? '0 : div_soft_re;
            o_soft_im        <= mag_zero ? '0 : div_soft_im;
        end
    end

    assign o_valid = r_valid;
    assign busy    = (r_state != ST_IDLE);

    // ---------------- assertions ----------------
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_err_zero_soft: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_error) |-> (o_soft_re == '0 && o_soft_im == '0))
        else $error("soft outputs not zero on divide error");

    a_bit_matches_re: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data_bits[0]) |-> (!o_equalized_re[31] && o_equalized_re != '0))
        else $error("real hard bit disagrees with equalized value");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside of divide phase");

    a_data_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == pce_pkg::OP_DATA) |=> busy)
        else $error("data beat taken without going busy");

endmodule
